// ===== hdl/dbfn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfn_pkg
// shared types, kind codes and name pattern tables for the file name classifier
// ----------------------------------------------------------------------------
package dbfn_pkg;

  localparam int LIT_COUNT    = 5;
  localparam int LIT_MANIFEST = 4;
  localparam int SUF_COUNT    = 4;
  localparam int NUM_W        = 64;
  localparam logic [3:0] POS_MAX = 4'd15;

  localparam logic [2:0] KIND_LOG        = 3'd0;
  localparam logic [2:0] KIND_LOCK       = 3'd1;
  localparam logic [2:0] KIND_TABLE      = 3'd2;
  localparam logic [2:0] KIND_DESCRIPTOR = 3'd3;
  localparam logic [2:0] KIND_CURRENT    = 3'd4;
  localparam logic [2:0] KIND_TEMP       = 3'd5;
  localparam logic [2:0] KIND_INFO       = 3'd6;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [2:0] {
    PH_START,
    PH_LITERAL,
    PH_MANIFEST,
    PH_NUMBER,
    PH_SUFFIX,
    PH_DEAD
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic             name_valid;
    logic [2:0]       file_kind;
    logic [NUM_W-1:0] file_number;
  } out_beat_t;

  // fixed names, left aligned in 9 bytes
  function automatic logic [71:0] lit_text(input logic [2:0] idx);
    logic [71:0] t;
    unique case (idx)
      3'd0:    t = {"CURRENT", 16'h0000};
      3'd1:    t = {"LOCK", 40'h0};
      3'd2:    t = {"LOG", 48'h0};
      3'd3:    t = {"LOG.old", 16'h0000};
      3'd4:    t = "MANIFEST-";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] lit_len(input logic [2:0] idx);
    logic [3:0] n;
    unique case (idx)
      3'd0:    n = 4'd7;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd3;
      3'd3:    n = 4'd7;
      3'd4:    n = 4'd9;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] lit_kind(input logic [2:0] idx);
    logic [2:0] k;
    unique case (idx)
      3'd0:    k = KIND_CURRENT;
      3'd1:    k = KIND_LOCK;
      3'd2:    k = KIND_INFO;
      3'd3:    k = KIND_INFO;
      3'd4:    k = KIND_DESCRIPTOR;
      default: k = KIND_LOG;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] lit_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [71:0] sh;
    sh = lit_text(idx) << {pos, 3'b000};
    return sh[71:64];
  endfunction

  // suffixes, left aligned in 6 bytes
  function automatic logic [47:0] suf_text(input logic [1:0] idx);
    logic [47:0] t;
    unique case (idx)
      2'd0: t = {".log", 16'h0000};
      2'd1: t = {".sst", 16'h0000};
      2'd2: t = {".ldb", 16'h0000};
      2'd3: t = ".dbtmp";
    endcase
    return t;
  endfunction

  function automatic logic [3:0] suf_len(input logic [1:0] idx);
    return (idx == 2'd3) ? 4'd6 : 4'd4;
  endfunction

  function automatic logic [2:0] suf_kind(input logic [1:0] idx);
    logic [2:0] k;
    unique case (idx)
      2'd0: k = KIND_LOG;
      2'd1: k = KIND_TABLE;
      2'd2: k = KIND_TABLE;
      2'd3: k = KIND_TEMP;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] suf_char(input logic [1:0] idx, input logic [3:0] pos);
    logic [47:0] sh;
    sh = suf_text(idx) << {pos, 3'b000};
    return sh[47:40];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dbfn_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfn_parse
// per-name parse state and the combinational step over one character
// ----------------------------------------------------------------------------
module dbfn_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire dbfn_pkg::in_beat_t  beat,
  output dbfn_pkg::out_beat_t      result
);

  localparam logic [3:0] MANIFEST_LEN = dbfn_pkg::lit_len(3'(dbfn_pkg::LIT_MANIFEST));

  dbfn_pkg::phase_t                   phase, phase_next;
  logic [dbfn_pkg::LIT_COUNT-1:0]     lit_cand, lit_cand_next;
  logic [3:0]                         pos, pos_next;
  logic [dbfn_pkg::SUF_COUNT-1:0]     suf_cand, suf_cand_next;
  logic [dbfn_pkg::NUM_W-1:0]         acc, acc_next;
  logic                               digit_seen, digit_seen_next;

  logic [7:0]                         ch;
  logic                               is_digit;
  logic [3:0]                         digit;
  dbfn_pkg::phase_t                   eff_phase;
  logic [dbfn_pkg::LIT_COUNT-1:0]     lit_keep;
  logic [3:0]                         pos_inc;
  logic                               lit_hit;
  logic [2:0]                         lit_hit_kind;
  logic [dbfn_pkg::NUM_W+3:0]         acc_sum;
  logic                               ovf;
  logic                               to_suffix;
  logic                               in_suffix;
  logic [3:0]                         suf_pos;
  logic [3:0]                         suf_pos_inc;
  logic [dbfn_pkg::SUF_COUNT-1:0]     suf_keep;
  logic                               suf_hit;
  logic [2:0]                         suf_hit_kind;

  assign ch       = beat.char_code;
  assign is_digit = (ch >= dbfn_pkg::CHAR_ZERO) && (ch <= dbfn_pkg::CHAR_NINE);
  assign digit    = ch[3:0];

  // first character picks number or fixed name
  assign eff_phase = (phase == dbfn_pkg::PH_START) ?
                     (is_digit ? dbfn_pkg::PH_NUMBER : dbfn_pkg::PH_LITERAL) : phase;

  assign pos_inc = (pos == dbfn_pkg::POS_MAX) ? pos : pos + 4'd1;

  // acc * 10 + digit, carry bits flag overflow past 64 bits
  assign acc_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                 + {{dbfn_pkg::NUM_W{1'b0}}, digit};
  assign ovf     = |acc_sum[dbfn_pkg::NUM_W+3:dbfn_pkg::NUM_W];

  assign to_suffix   = (eff_phase == dbfn_pkg::PH_NUMBER) && !is_digit && digit_seen;
  assign in_suffix   = (eff_phase == dbfn_pkg::PH_SUFFIX) || to_suffix;
  assign suf_pos     = to_suffix ? 4'd0 : pos;
  assign suf_pos_inc = (suf_pos == dbfn_pkg::POS_MAX) ? suf_pos : suf_pos + 4'd1;

  always_comb begin
    lit_hit      = 1'b0;
    lit_hit_kind = dbfn_pkg::KIND_LOG;
    for (int i = 0; i < dbfn_pkg::LIT_COUNT; i++) begin
      lit_keep[i] = lit_cand[i] && (pos < dbfn_pkg::lit_len(3'(i)))
                  && (dbfn_pkg::lit_char(3'(i), pos) == ch);
    end
    // lowest index wins
    for (int i = dbfn_pkg::LIT_COUNT - 1; i >= 0; i--) begin
      if (lit_keep[i] && (i != dbfn_pkg::LIT_MANIFEST)
          && (dbfn_pkg::lit_len(3'(i)) == pos_inc)) begin
        lit_hit      = 1'b1;
        lit_hit_kind = dbfn_pkg::lit_kind(3'(i));
      end
    end
  end

  always_comb begin
    suf_hit      = 1'b0;
    suf_hit_kind = dbfn_pkg::KIND_LOG;
    for (int i = 0; i < dbfn_pkg::SUF_COUNT; i++) begin
      suf_keep[i] = suf_cand[i] && (suf_pos < dbfn_pkg::suf_len(2'(i)))
                  && (dbfn_pkg::suf_char(2'(i), suf_pos) == ch);
    end
    for (int i = dbfn_pkg::SUF_COUNT - 1; i >= 0; i--) begin
      if (suf_keep[i] && (dbfn_pkg::suf_len(2'(i)) == suf_pos_inc)) begin
        suf_hit      = 1'b1;
        suf_hit_kind = dbfn_pkg::suf_kind(2'(i));
      end
    end
  end

  // next state
  always_comb begin
    phase_next      = phase;
    lit_cand_next   = lit_cand;
    pos_next        = pos;
    suf_cand_next   = suf_cand;
    acc_next        = acc;
    digit_seen_next = digit_seen;
    if (beat.last_char) begin
      phase_next      = dbfn_pkg::PH_START;
      lit_cand_next   = '1;
      pos_next        = 4'd0;
      suf_cand_next   = '1;
      acc_next        = '0;
      digit_seen_next = 1'b0;
    end else if (in_suffix) begin
      suf_cand_next = suf_keep;
      pos_next      = suf_pos_inc;
      phase_next    = (suf_keep == '0) ? dbfn_pkg::PH_DEAD : dbfn_pkg::PH_SUFFIX;
    end else begin
      unique case (eff_phase)
        dbfn_pkg::PH_LITERAL: begin
          lit_cand_next = lit_keep;
          pos_next      = pos_inc;
          if (lit_keep == '0) begin
            phase_next = dbfn_pkg::PH_DEAD;
          end else if (lit_keep[dbfn_pkg::LIT_MANIFEST] && (pos_inc == MANIFEST_LEN)) begin
            phase_next = dbfn_pkg::PH_MANIFEST;
          end else begin
            phase_next = dbfn_pkg::PH_LITERAL;
          end
        end
        dbfn_pkg::PH_MANIFEST, dbfn_pkg::PH_NUMBER: begin
          if (!is_digit || ovf) begin
            phase_next = dbfn_pkg::PH_DEAD;
          end else begin
            phase_next      = eff_phase;
            acc_next        = acc_sum[dbfn_pkg::NUM_W-1:0];
            digit_seen_next = 1'b1;
          end
        end
        dbfn_pkg::PH_START, dbfn_pkg::PH_SUFFIX, dbfn_pkg::PH_DEAD: begin
          phase_next = dbfn_pkg::PH_DEAD;
        end
        default: phase_next = dbfn_pkg::PH_DEAD;
      endcase
    end
  end

  // result of a last character
  always_comb begin
    result = '0;
    if (in_suffix) begin
      if (suf_hit) begin
        result.name_valid  = 1'b1;
        result.file_kind   = suf_hit_kind;
        result.file_number = acc;
      end
    end else if (eff_phase == dbfn_pkg::PH_LITERAL) begin
      if (lit_hit) begin
        result.name_valid = 1'b1;
        result.file_kind  = lit_hit_kind;
      end
    end else if (eff_phase == dbfn_pkg::PH_MANIFEST) begin
      if (is_digit && !ovf) begin
        result.name_valid  = 1'b1;
        result.file_kind   = dbfn_pkg::KIND_DESCRIPTOR;
        result.file_number = acc_sum[dbfn_pkg::NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dbfn_pkg::PH_START;
      lit_cand   <= '1;
      pos        <= 4'd0;
      suf_cand   <= '1;
      acc        <= '0;
      digit_seen <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      lit_cand   <= lit_cand_next;
      pos        <= pos_next;
      suf_cand   <= suf_cand_next;
      acc        <= acc_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/db_file_name_classifier_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: a character beat is captured in the input register and then parsed; a final
//   character's result is loaded into the result register when it is parsed
// throughput: one character per cycle while char_stall is low, limited by the parse step
// reset: rst (synchronous) empties both registers and returns the parser to the
//   start of a name
// ----------------------------------------------------------------------------
// db_file_name_classifier_core
// classifies a file name streamed one character per beat, one result per name
// ----------------------------------------------------------------------------
module db_file_name_classifier_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  output logic                     char_stall,
  input  wire dbfn_pkg::in_beat_t  char_beat,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output dbfn_pkg::out_beat_t      result_beat
);

  // input register
  logic                in_full, in_full_next;
  dbfn_pkg::in_beat_t  in_q;
  // result register
  logic                res_full, res_full_next;
  dbfn_pkg::out_beat_t res_q;

  logic                char_take;
  logic                advance;
  logic                step;
  logic                res_load;
  dbfn_pkg::out_beat_t step_result;

  // only a final character needs room in the result register; the others
  // move on even while a result waits downstream
  assign advance    = !(in_q.last_char && res_full && result_stall);
  assign step       = in_full && advance;
  assign res_load   = step && in_q.last_char;
  assign char_stall = in_full && !advance;
  assign char_take  = char_valid && !char_stall;

  assign in_full_next  = char_take ? 1'b1 : (step ? 1'b0 : in_full);
  assign res_full_next = res_load ? 1'b1 : (result_stall ? res_full : 1'b0);

  dbfn_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (in_q),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      in_full  <= in_full_next;
      res_full <= res_full_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (char_take) begin
      in_q <= char_beat;
    end
    if (res_load) begin
      res_q <= step_result;
    end
  end

  assign result_valid = res_full;
  assign result_beat  = res_q;

  // a new result only ever comes from a final character in the input register
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(in_full && in_q.last_char))
    else $error("result appeared without a final character");

  // characters that do not end a name never hold up the input
  a_mid_no_stall: assert property (@(posedge clk) disable iff (rst)
    (in_full && !in_q.last_char) |-> !char_stall)
    else $error("stall on a non-final character");

  // invalid names carry zero kind and number
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_beat.name_valid) |->
      (result_beat.file_kind == dbfn_pkg::KIND_LOG && result_beat.file_number == '0))
    else $error("invalid name with nonzero fields");

  // stall toward the sender only while a finished result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (result_valid && result_stall))
    else $error("input stalled with no held result");

endmodule
`default_nettype wire
